FILE: hw/rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, register indexes and helper functions for the
// environmental sensor compensation pipeline.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEMP_TRIM  = 3'd0,
        REG_PRES_LOW   = 3'd1,
        REG_PRES_HIGH  = 3'd2,
        REG_PRES_LAST  = 3'd3,
        REG_HUM_TRIM   = 3'd4
    } cfg_reg_t;

    localparam int IN_W  = 56;
    localparam int OUT_W = 56;

    // stage counts
    localparam int TF_LAT    = 5;
    localparam int TEMP_LAT  = 7;
    localparam int HUM_LAT   = 14;
    localparam int PRES_LAT  = 87;
    localparam int MUL_LAT   = 2;
    localparam int DIV_STEPS = 64;
    localparam int TOTAL_LAT = TF_LAT + PRES_LAT;

    localparam logic signed [31:0] TEMP_MIN  = -32'sd4000;
    localparam logic signed [31:0] TEMP_MAX  = 32'sd8500;
    localparam logic signed [31:0] HUM_E_MAX = 32'sd419430400;
    localparam logic [31:0]        PRES_MIN  = 32'd3000000;
    localparam logic [31:0]        PRES_MAX  = 32'd11000000;

    // signed divide by 2**k, truncating toward zero
    function automatic logic signed [31:0] sdiv32(input logic signed [31:0] x,
                                                  input int unsigned k);
        logic [31:0]        bias;
        logic signed [31:0] s;
        bias = x[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        s    = x + $signed(bias);
        return s >>> k;
    endfunction

    function automatic logic signed [63:0] sdiv64(input logic signed [63:0] x,
                                                  input int unsigned k);
        logic [63:0]        bias;
        logic signed [63:0] s;
        bias = x[63] ? ((64'd1 << k) - 64'd1) : 64'd0;
        s    = x + $signed(bias);
        return s >>> k;
    endfunction

    function automatic logic signed [63:0] sx16_64(input logic [15:0] v);
        return $signed({{48{v[15]}}, v});
    endfunction

endpackage

FILE: hw/rtl/env_sensor_compensation_top.sv
// ----------------------------------------------------------------------------
// env_sensor_compensation_top
// Integer temperature, humidity and pressure compensation of one raw sample.
//
//   channel  | dir | handshake                | contents
//   s_       | in  | s_tvalid / s_tready      | raw sample word
//   m_       | out | m_tvalid / m_tready      | compensated result word
//   cfg_     | in  | cfg_valid / cfg_ready    | trim register write
//
// One word per cycle in and out while m_tready is high; the latency is set by the
// pressure path (64-stage divider plus 64-bit multipliers) behind the 5-stage t_fine.
// aresetn clears valid bits, the input skid stage and the trim registers.
// A result held by m_tready low freezes the whole pipeline; one more input
// word is held in the skid stage, then s_tready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module env_sensor_compensation_top import esc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [19:0] raw_pressure, [39:20] raw_temperature, [55:40] raw_humidity
    input  logic [IN_W-1:0]      s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [14:0] temperature_centi, [31:15] humidity_q10, [55:32] pressure_centi_pa
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);
    logic [47:0]           temp_trim_reg;
    logic [63:0]           pres_low_reg, pres_high_reg, hum_trim_reg;
    logic [15:0]           pres_last_reg;
    logic                  skid_valid_reg;
    logic [IN_W-1:0]       skid_data_reg;
    logic [TOTAL_LAT-1:0]  vld_reg;
    logic                  adv, s_acc, in_valid;
    logic [IN_W-1:0]       in_data;
    logic signed [31:0]    tfine;
    logic signed [14:0]    temp_w;
    logic [14:0]           temp_d;
    logic [16:0]           hum_w, hum_d;
    logic [23:0]           pres_w;
    logic [19:0]           rp_d;
    logic [15:0]           rh_d;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_trim_reg <= '0;
            pres_low_reg  <= '0;
            pres_high_reg <= '0;
            pres_last_reg <= '0;
            hum_trim_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TEMP_TRIM: temp_trim_reg <= cfg_data[47:0];
                REG_PRES_LOW:  pres_low_reg  <= cfg_data;
                REG_PRES_HIGH: pres_high_reg <= cfg_data;
                REG_PRES_LAST: pres_last_reg <= cfg_data[15:0];
                REG_HUM_TRIM:  hum_trim_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign in_valid = skid_valid_reg || s_acc;
    assign in_data  = skid_valid_reg ? skid_data_reg : s_tdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            vld_reg        <= '0;
        end else begin
            if (adv) begin
                skid_valid_reg <= 1'b0;
                vld_reg        <= {vld_reg[TOTAL_LAT-2:0], in_valid};
            end else if (s_acc) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_acc) begin
            skid_data_reg <= s_tdata;
        end
    end

    esc_temp u_temp (
        .aclk, .en(adv),
        .raw_temperature (in_data[39:20]),
        .temp_trim       (temp_trim_reg),
        .tfine           (tfine),
        .temperature_centi(temp_w)
    );

    esc_dly #(.W(20), .N(TF_LAT)) u_dly_rp (.aclk, .en(adv), .d(in_data[19:0]),  .q(rp_d));
    esc_dly #(.W(16), .N(TF_LAT)) u_dly_rh (.aclk, .en(adv), .d(in_data[55:40]), .q(rh_d));

    esc_hum u_hum (
        .aclk, .en(adv),
        .tfine        (tfine),
        .raw_humidity (rh_d),
        .hum_trim     (hum_trim_reg),
        .humidity_q10 (hum_w)
    );

    esc_pres u_pres (
        .aclk, .en(adv),
        .tfine             (tfine),
        .raw_pressure      (rp_d),
        .pres_trim_low     (pres_low_reg),
        .pres_trim_high    (pres_high_reg),
        .pres_trim_last    (pres_last_reg),
        .pressure_centi_pa (pres_w)
    );

    esc_dly #(.W(15), .N(TOTAL_LAT - TEMP_LAT)) u_dly_temp (
        .aclk, .en(adv), .d(temp_w), .q(temp_d)
    );
    esc_dly #(.W(17), .N(PRES_LAT - HUM_LAT)) u_dly_hum (
        .aclk, .en(adv), .d(hum_w), .q(hum_d)
    );

    assign m_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_tdata  = {pres_w, hum_d, temp_d};
endmodule

FILE: hw/rtl/esc_dly.sv
// ----------------------------------------------------------------------------
// esc_dly
// Fixed-length delay line that advances with the pipeline enable.
// ----------------------------------------------------------------------------
module esc_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] pipe_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    assign q = pipe_reg[N-1];
endmodule

FILE: hw/rtl/esc_mul64.sv
// ----------------------------------------------------------------------------
// esc_mul64
// Two-stage 64x64 multiplier, low 64 bits of the product (wraps).
// ----------------------------------------------------------------------------
module esc_mul64 import esc_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);
    logic [63:0] ll_reg;
    logic [31:0] lh_reg;
    logic [31:0] hl_reg;
    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
            lh_reg <= a[31:0] * b[63:32];
            hl_reg <= a[63:32] * b[31:0];
            p_reg  <= ll_reg + {lh_reg + hl_reg, 32'd0};
        end
    end

    assign p = p_reg;
endmodule

FILE: hw/rtl/esc_div.sv
// ----------------------------------------------------------------------------
// esc_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module esc_div import esc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [63:0] quo
);
    logic [63:0]        q_reg   [DIV_STEPS+1];
    logic [63:0]        r_reg   [DIV_STEPS+1];
    logic [63:0]        d_reg   [DIV_STEPS+1];
    logic               neg_reg [DIV_STEPS+1];
    logic signed [63:0] quo_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg[0]   <= num[63] ? (~num + 64'd1) : num;
            d_reg[0]   <= den[63] ? (~den + 64'd1) : den;
            r_reg[0]   <= '0;
            neg_reg[0] <= num[63] ^ den[63];
            quo_reg    <= neg_reg[DIV_STEPS] ? $signed(-q_reg[DIV_STEPS])
                                             : $signed(q_reg[DIV_STEPS]);
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        logic [64:0] trial;
        logic [64:0] diff;
        logic        ge;
        assign trial = {r_reg[i], q_reg[i][63]};
        assign diff  = trial - {1'b0, d_reg[i]};
        assign ge    = trial >= {1'b0, d_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i+1]   <= ge ? diff[63:0] : trial[63:0];
                q_reg[i+1]   <= {q_reg[i][62:0], ge};
                d_reg[i+1]   <= d_reg[i];
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    assign quo = quo_reg;
endmodule

FILE: hw/rtl/esc_temp.sv
// ----------------------------------------------------------------------------
// esc_temp
// Temperature stages: fine temperature after five stages, result after seven.
// ----------------------------------------------------------------------------
module esc_temp import esc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [19:0]        raw_temperature,
    input  logic [47:0]        temp_trim,
    output logic signed [31:0] tfine,
    output logic signed [14:0] temperature_centi
);
    logic signed [31:0] t1, t2, t3;
    logic signed [31:0] a1_reg, b1_reg, ma_reg, mb_reg, a3_reg, b3_reg;
    logic signed [31:0] a4_reg, mb2_reg, tf_reg, t6_reg;
    logic signed [31:0] tq;
    logic signed [14:0] temp_reg;

    assign t1 = $signed({16'd0, temp_trim[15:0]});
    assign t2 = $signed({{16{temp_trim[31]}}, temp_trim[31:16]});
    assign t3 = $signed({{16{temp_trim[47]}}, temp_trim[47:32]});
    assign tq = sdiv32(t6_reg, 8);

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg  <= $signed({15'd0, raw_temperature[19:3]}) - (t1 <<< 1);
            b1_reg  <= $signed({16'd0, raw_temperature[19:4]}) - t1;
            ma_reg  <= a1_reg * t2;
            mb_reg  <= b1_reg * b1_reg;
            a3_reg  <= sdiv32(ma_reg, 11);
            b3_reg  <= sdiv32(mb_reg, 12);
            a4_reg  <= a3_reg;
            mb2_reg <= b3_reg * t3;
            tf_reg  <= a4_reg + sdiv32(mb2_reg, 14);
            t6_reg  <= (tf_reg <<< 2) + tf_reg + 32'sd128;
            if (tq < TEMP_MIN) begin
                temp_reg <= TEMP_MIN[14:0];
            end else if (tq > TEMP_MAX) begin
                temp_reg <= TEMP_MAX[14:0];
            end else begin
                temp_reg <= tq[14:0];
            end
        end
    end

    assign tfine             = tf_reg;
    assign temperature_centi = temp_reg;
endmodule

FILE: hw/rtl/esc_hum.sv
// ----------------------------------------------------------------------------
// esc_hum
// Humidity stages, 32-bit wrapping arithmetic, fourteen stages from t_fine.
// ----------------------------------------------------------------------------
module esc_hum import esc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] tfine,
    input  logic [15:0]        raw_humidity,
    input  logic [63:0]        hum_trim,
    output logic [16:0]        humidity_q10
);
    logic signed [31:0] h1, h2, h3, h4, h5, h6;
    logic signed [31:0] a_reg, d_reg, b6_reg, c6_reg;
    logic [15:0]        rh1_reg, rh2_reg;
    logic signed [31:0] e1_reg, b2_reg, c2_reg;
    logic signed [31:0] e4_reg, m_reg, e5_reg, d2_reg, e6_reg, m2_reg;
    logic signed [31:0] e7_reg, b3_reg, c3_reg, q_reg, c9_reg;
    logic signed [31:0] sq_reg, c10_reg, d3_reg, c11_reg, m3_reg, c12_reg;
    logic signed [31:0] e_reg;
    logic signed [31:0] e_calc;
    logic [16:0]        hum_reg;

    assign h1 = $signed({24'd0, hum_trim[7:0]});
    assign h2 = $signed({{16{hum_trim[23]}}, hum_trim[23:8]});
    assign h3 = $signed({24'd0, hum_trim[31:24]});
    assign h4 = $signed({{20{hum_trim[43]}}, hum_trim[43:32]});
    assign h5 = $signed({{20{hum_trim[55]}}, hum_trim[55:44]});
    assign h6 = $signed({{24{hum_trim[63]}}, hum_trim[63:56]});

    assign e_calc = c12_reg - sdiv32(m3_reg, 4);

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg   <= tfine - 32'sd76800;
            rh1_reg <= raw_humidity;
            d_reg   <= h5 * a_reg;
            b6_reg  <= a_reg * h6;
            c6_reg  <= a_reg * h3;
            rh2_reg <= rh1_reg;
            e1_reg  <= sdiv32(($signed({2'd0, rh2_reg, 14'd0}) - (h4 <<< 20)) - d_reg
                              + 32'sd16384, 15);
            b2_reg  <= sdiv32(b6_reg, 10);
            c2_reg  <= sdiv32(c6_reg, 11) + 32'sd32768;
            e4_reg  <= e1_reg;
            m_reg   <= b2_reg * c2_reg;
            e5_reg  <= e4_reg;
            d2_reg  <= sdiv32(m_reg, 10) + 32'sd2097152;
            e6_reg  <= e5_reg;
            m2_reg  <= d2_reg * h2;
            e7_reg  <= e6_reg;
            b3_reg  <= sdiv32(m2_reg + 32'sd8192, 14);
            c3_reg  <= e7_reg * b3_reg;
            q_reg   <= sdiv32(c3_reg, 15);
            c9_reg  <= c3_reg;
            sq_reg  <= q_reg * q_reg;
            c10_reg <= c9_reg;
            d3_reg  <= sdiv32(sq_reg, 7);
            c11_reg <= c10_reg;
            m3_reg  <= d3_reg * h1;
            c12_reg <= c11_reg;
            if (e_calc < 32'sd0) begin
                e_reg <= '0;
            end else if (e_calc > HUM_E_MAX) begin
                e_reg <= HUM_E_MAX;
            end else begin
                e_reg <= e_calc;
            end
            hum_reg <= e_reg[28:12];
        end
    end

    assign humidity_q10 = hum_reg;
endmodule

FILE: hw/rtl/esc_pres.sv
// ----------------------------------------------------------------------------
// esc_pres
// Pressure stages, 64-bit wrapping arithmetic with a pipelined divide,
// 87 stages from t_fine.
// ----------------------------------------------------------------------------
module esc_pres import esc_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] tfine,
    input  logic [19:0]        raw_pressure,
    input  logic [63:0]        pres_trim_low,
    input  logic [63:0]        pres_trim_high,
    input  logic [15:0]        pres_trim_last,
    output logic [23:0]        pressure_centi_pa
);
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] x1_reg;
    logic [63:0]        sq_w, x1p5_w, x1p2_w, sqp6_w, sqp3_w, x1p5_d, x1p2_d;
    logic signed [63:0] x2_reg, x1b_reg, s_reg;
    logic [63:0]        x2_d, sp1_w;
    logic [19:0]        rp_d;
    logic signed [63:0] x1c_reg, num0_reg, num_reg, den_reg;
    logic               nz_reg, nz_d;
    logic signed [63:0] q_w, q78_reg, qa_reg;
    logic [63:0]        p9qa_w, p8q_w, qa_d, m_w, p8q_d, q_d;
    logic signed [63:0] t1_reg, t2_reg, q83_reg, sum_reg, x4b_reg, y_reg;
    logic signed [63:0] hd, r;
    logic [31:0]        r32;
    logic [23:0]        pres_reg;

    assign p1 = $signed({48'd0, pres_trim_low[15:0]});
    assign p2 = sx16_64(pres_trim_low[31:16]);
    assign p3 = sx16_64(pres_trim_low[47:32]);
    assign p4 = sx16_64(pres_trim_low[63:48]);
    assign p5 = sx16_64(pres_trim_high[15:0]);
    assign p6 = sx16_64(pres_trim_high[31:16]);
    assign p7 = sx16_64(pres_trim_high[47:32]);
    assign p8 = sx16_64(pres_trim_high[63:48]);
    assign p9 = sx16_64(pres_trim_last);

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= $signed({{32{tfine[31]}}, tfine}) - 64'sd128000;
        end
    end

    esc_mul64 u_mul_sq   (.aclk, .en, .a(x1_reg), .b(x1_reg), .p(sq_w));
    esc_mul64 u_mul_x1p5 (.aclk, .en, .a(x1_reg), .b(p5),     .p(x1p5_w));
    esc_mul64 u_mul_x1p2 (.aclk, .en, .a(x1_reg), .b(p2),     .p(x1p2_w));
    esc_mul64 u_mul_sqp6 (.aclk, .en, .a(sq_w),   .b(p6),     .p(sqp6_w));
    esc_mul64 u_mul_sqp3 (.aclk, .en, .a(sq_w),   .b(p3),     .p(sqp3_w));

    esc_dly #(.W(64), .N(MUL_LAT)) u_dly_x1p5 (.aclk, .en, .d(x1p5_w), .q(x1p5_d));
    esc_dly #(.W(64), .N(MUL_LAT)) u_dly_x1p2 (.aclk, .en, .d(x1p2_w), .q(x1p2_d));

    always_ff @(posedge aclk) begin
        if (en) begin
            x2_reg  <= $signed(sqp6_w) + ($signed(x1p5_d) <<< 17) + (p4 <<< 35);
            x1b_reg <= sdiv64($signed(sqp3_w), 8) + ($signed(x1p2_d) <<< 12);
            s_reg   <= 64'sh0000_8000_0000_0000 + x1b_reg;
        end
    end

    esc_mul64 u_mul_sp1 (.aclk, .en, .a(s_reg), .b(p1), .p(sp1_w));
    esc_dly #(.W(64), .N(3)) u_dly_x2 (.aclk, .en, .d(x2_reg), .q(x2_d));
    esc_dly #(.W(20), .N(9)) u_dly_rp (.aclk, .en, .d(raw_pressure), .q(rp_d));

    always_ff @(posedge aclk) begin
        if (en) begin
            x1c_reg  <= sdiv64($signed(sp1_w), 33);
            num0_reg <= ((64'sd1048576 - $signed({44'd0, rp_d})) <<< 31)
                        - $signed(x2_d);
            num_reg  <= (num0_reg <<< 11) + (num0_reg <<< 10) + (num0_reg <<< 5)
                        + (num0_reg <<< 4) + (num0_reg <<< 2) + num0_reg;
            den_reg  <= x1c_reg;
            nz_reg   <= x1c_reg != 64'sd0;
        end
    end

    esc_div u_div (.aclk, .en, .num(num_reg), .den(den_reg), .quo(q_w));
    esc_dly #(.W(1), .N(75)) u_dly_nz (.aclk, .en, .d(nz_reg), .q(nz_d));

    always_ff @(posedge aclk) begin
        if (en) begin
            qa_reg  <= sdiv64(q_w, 13);
            q78_reg <= q_w;
        end
    end

    esc_mul64 u_mul_p9qa (.aclk, .en, .a(p9),     .b(qa_reg),  .p(p9qa_w));
    esc_mul64 u_mul_p8q  (.aclk, .en, .a(p8),     .b(q78_reg), .p(p8q_w));
    esc_dly #(.W(64), .N(MUL_LAT)) u_dly_qa (.aclk, .en, .d(qa_reg), .q(qa_d));
    esc_mul64 u_mul_m    (.aclk, .en, .a(p9qa_w), .b(qa_d),    .p(m_w));
    esc_dly #(.W(64), .N(MUL_LAT))   u_dly_p8q (.aclk, .en, .d(p8q_w),   .q(p8q_d));
    esc_dly #(.W(64), .N(2*MUL_LAT)) u_dly_q   (.aclk, .en, .d(q78_reg), .q(q_d));

    assign hd  = sdiv64(x4b_reg, 1);
    assign r   = sdiv64(y_reg, 7);
    assign r32 = r[31:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg  <= sdiv64($signed(m_w), 25);
            t2_reg  <= sdiv64($signed(p8q_d), 19);
            q83_reg <= $signed(q_d);
            sum_reg <= q83_reg + t1_reg + t2_reg;
            x4b_reg <= sdiv64(sum_reg, 8) + (p7 <<< 4);
            y_reg   <= (hd <<< 6) + (hd <<< 5) + (hd <<< 2);
            if (!nz_d || r32 < PRES_MIN) begin
                pres_reg <= PRES_MIN[23:0];
            end else if (r32 > PRES_MAX) begin
                pres_reg <= PRES_MAX[23:0];
            end else begin
                pres_reg <= r32[23:0];
            end
        end
    end

    assign pressure_centi_pa = pres_reg;
endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for env_sensor_compensation_top: random and directed
// raw samples under several trim settings, each result checked field by field
// against an in-bench integer compensation model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import esc_pkg::*;

    typedef struct packed {
        logic [23:0] pres;
        logic [16:0] hum;
        logic [14:0] temp;
    } comp_word_t;

    int n_errors = 0;

    function automatic void report(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_v);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
        n_errors++;
    endfunction

    class comp_scoreboard;
        logic [47:0] t_trim;
        logic [63:0] p_low, p_high, h_trim;
        logic [15:0] p_last;
        comp_word_t  pending[$];

        function new();
            t_trim = 0; p_low = 0; p_high = 0; p_last = 0; h_trim = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [63:0] v);
            case (idx)
                REG_TEMP_TRIM: t_trim = v[47:0];
                REG_PRES_LOW:  p_low = v;
                REG_PRES_HIGH: p_high = v;
                REG_PRES_LAST: p_last = v[15:0];
                REG_HUM_TRIM:  h_trim = v;
                default: ;
            endcase
        endfunction

        function comp_word_t compensate(logic [55:0] w);
            logic signed [31:0] rp, rt, rh, t1, t2, t3, h1, h2, h3, h4, h5, h6;
            logic signed [31:0] a, b, c, d, e, tfine, tc;
            logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, x1, x2, x4;
            logic [31:0] hum, pres;
            comp_word_t r;
            rp = {12'd0, w[19:0]}; rt = {12'd0, w[39:20]}; rh = {16'd0, w[55:40]};
            t1 = {16'd0, t_trim[15:0]};
            t2 = {{16{t_trim[31]}}, t_trim[31:16]};
            t3 = {{16{t_trim[47]}}, t_trim[47:32]};
            p1 = {48'd0, p_low[15:0]};
            p2 = {{48{p_low[31]}}, p_low[31:16]};
            p3 = {{48{p_low[47]}}, p_low[47:32]};
            p4 = {{48{p_low[63]}}, p_low[63:48]};
            p5 = {{48{p_high[15]}}, p_high[15:0]};
            p6 = {{48{p_high[31]}}, p_high[31:16]};
            p7 = {{48{p_high[47]}}, p_high[47:32]};
            p8 = {{48{p_high[63]}}, p_high[63:48]};
            p9 = {{48{p_last[15]}}, p_last};
            h1 = {24'd0, h_trim[7:0]};
            h2 = {{16{h_trim[23]}}, h_trim[23:8]};
            h3 = {24'd0, h_trim[31:24]};
            h4 = {{20{h_trim[43]}}, h_trim[43:32]};
            h5 = {{20{h_trim[55]}}, h_trim[55:44]};
            h6 = {{24{h_trim[63]}}, h_trim[63:56]};

            a = rt / 8 - t1 * 2;
            a = (a * t2) / 2048;
            b = rt / 16 - t1;
            b = (((b * b) / 4096) * t3) / 16384;
            tfine = a + b;
            tc = (tfine * 5 + 128) / 256;
            if (tc < -4000) tc = -4000;
            else if (tc > 8500) tc = 8500;

            a = tfine - 76800;
            b = rh * 16384;
            c = h4 * 1048576;
            d = h5 * a;
            e = (b - c - d + 16384) / 32768;
            b = (a * h6) / 1024;
            c = (a * h3) / 2048;
            d = (b * (c + 32768)) / 1024 + 2097152;
            b = (d * h2 + 8192) / 16384;
            c = e * b;
            d = ((c / 32768) * (c / 32768)) / 128;
            e = c - (d * h1) / 16;
            if (e < 0) e = 0;
            if (e > 419430400) e = 419430400;
            hum = e / 4096;
            if (hum > 102400) hum = 102400;

            x1 = 64'(tfine) - 128000;
            x2 = x1 * x1 * p6;
            x2 = x2 + x1 * p5 * 131072;
            x2 = x2 + p4 * 64'sd34359738368;
            x1 = (x1 * x1 * p3) / 256 + x1 * p2 * 4096;
            x1 = ((64'sd140737488355328 + x1) * p1) / 64'sd8589934592;
            if (x1 != 0) begin
                x4 = 64'sd1048576 - 64'(rp);
                x4 = (x4 * 64'sd2147483648 - x2) * 3125;
                if (x1 == -1) x4 = -x4;
                else x4 = x4 / x1;
                x1 = (p9 * (x4 / 8192) * (x4 / 8192)) / 33554432;
                x2 = (p8 * x4) / 524288;
                x4 = (x4 + x1 + x2) / 256 + p7 * 16;
                x4 = ((x4 / 2) * 100) / 128;
                pres = x4[31:0];
                if (pres < 3000000) pres = 3000000;
                else if (pres > 11000000) pres = 11000000;
            end else begin
                pres = 3000000;
            end
            r.temp = tc[14:0];
            r.hum = hum[16:0];
            r.pres = pres[23:0];
            return r;
        endfunction

        function void note_sample(logic [55:0] w);
            pending.push_back(compensate(w));
        endfunction

        function void check_result(logic [55:0] w);
            comp_word_t got, exp_r;
            got = w;
            if (pending.size() == 0) begin
                report("unexpected word", 64'(w), 64'd0);
                return;
            end
            exp_r = pending.pop_front();
            if (got.temp !== exp_r.temp)
                report("temperature_centi", 64'(got.temp), 64'(exp_r.temp));
            if (got.hum !== exp_r.hum)
                report("humidity_q10", 64'(got.hum), 64'(exp_r.hum));
            if (got.pres !== exp_r.pres)
                report("pressure_centi_pa", 64'(got.pres), 64'(exp_r.pres));
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
    logic [55:0] s_tdata = 0, m_tdata;
    logic cfg_valid = 0, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [63:0] cfg_data = 0;
    longint unsigned cycles = 0;
    comp_scoreboard sb = new();

    always #5 aclk = ~aclk;

    env_sensor_compensation_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (cycles > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side back-pressure
    bit no_stall = 0;
    initial begin
        int g;
        forever begin
            @(negedge aclk);
            g = no_stall ? 0 : gap_len();
            if (g == 0) m_tready <= 1;
            else begin
                m_tready <= 0;
                repeat (g - 1) @(negedge aclk);
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
        @(negedge aclk);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic send_sample(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {rh, rt, rp};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample({rh, rt, rp});
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (TOTAL_LAT + 10) @(negedge aclk);
    endtask

    // typical, zero, all-ones or extreme trim set by mode, else a jittered (sometimes fully random) one
    task automatic set_trims(int mode);
        logic [63:0] tt, pl, ph, pz, ht;
        case (mode)
            0: begin
                tt = 64'({16'd50, 16'd26435, 16'd27504});
                pl = {16'd2855, 16'hD0BF, 16'hD5D0, 16'd36477};
                ph = {16'hFFF9, 16'd15500, 16'hFFF9, 16'd140};
                pz = 64'd6000;
                ht = {8'd30, 12'd50, 12'd312, 8'd0, 16'd360, 8'd75};
            end
            1: begin tt = 0; pl = 0; ph = 0; pz = 0; ht = 0; end
            2: begin tt = '1; pl = '1; ph = '1; pz = 64'hFFFF; ht = '1; end
            3: begin
                tt = 64'({16'h7FFF, 16'h8000, 16'hFFFF});
                pl = {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF};
                ph = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
                pz = 64'h7FFF;
                ht = {8'h80, 12'h7FF, 12'h800, 8'hFF, 16'h8000, 8'hFF};
            end
            default: begin
                tt = 64'({16'd50 + 16'($urandom_range(0, 20)),
                      16'd26435 + 16'($urandom_range(0, 200)),
                      16'($urandom_range(20000, 35000))});
                pl = {16'd2855 + 16'($urandom_range(0, 500)), 16'hD0BF,
                      16'hD5D0 + 16'($urandom_range(0, 300)), 16'($urandom_range(30000, 40000))};
                ph = {16'hFFF9, 16'd15500, 16'hFFF9 - 16'($urandom_range(0, 5)),
                      16'($urandom_range(0, 300))};
                pz = 64'($urandom_range(4000, 8000));
                ht = {8'($urandom_range(20, 40)), 12'($urandom_range(0, 100)),
                      12'($urandom_range(250, 400)), 8'd0, 16'($urandom_range(300, 420)),
                      8'($urandom_range(50, 100))};
                if ($urandom_range(0, 3) == 0) begin
                    tt = {$urandom, $urandom}; pl = {$urandom, $urandom};
                    ph = {$urandom, $urandom}; pz = 64'($urandom); ht = {$urandom, $urandom};
                end
            end
        endcase
        write_reg(REG_TEMP_TRIM, tt);
        write_reg(REG_PRES_LOW, pl);
        write_reg(REG_PRES_HIGH, ph);
        write_reg(REG_PRES_LAST, pz);
        write_reg(REG_HUM_TRIM, ht);
    endtask

    task automatic random_block(int n);
        logic [19:0] rp, rt;
        logic [15:0] rh;
        bit gaps;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) < 7) begin
                rp = 20'($urandom_range(200000, 700000));
                rt = 20'($urandom_range(400000, 650000));
                rh = 16'($urandom_range(20000, 40000));
            end else begin
                rp = 20'($urandom); rt = 20'($urandom); rh = 16'($urandom);
            end
            gaps = (i % 100) > 30;
            send_sample(rp, rt, rh, gaps);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        // reset trims: divisor zero path
        send_sample(20'd0, 20'd0, 16'd0, 0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
        drain();

        set_trims(0);
        send_sample(20'd415148, 20'd519888, 16'd30000, 0);
        send_sample(20'd0, 20'd0, 16'd0, 0);
        send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
        send_sample(20'd0, 20'hFFFFF, 16'd0, 1);
        send_sample(20'hFFFFF, 20'd0, 16'hFFFF, 1);
        send_sample(20'hAAAAA, 20'h55555, 16'hAAAA, 0);
        send_sample(20'h55555, 20'hAAAAA, 16'h5555, 0);
        send_sample(20'd1048575, 20'd300000, 16'd65535, 1);
        send_sample(20'd500000, 20'd700000, 16'd60000, 0);
        send_sample(20'd500000, 20'd350000, 16'd10000, 0);
        drain();

        for (int ph = 2; ph < 12; ph++) begin
            set_trims(ph < 4 ? ph : 4);
            no_stall = (ph == 5);
            send_sample(20'd0, 20'd0, 16'd0, 0);
            send_sample(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 0);
            random_block(ph < 4 ? 40 : 130);
            drain();
        end
        set_trims(1);
        random_block(30);
        drain();
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
